@@ hw/rtl/frr_pkg.sv @@
// Shared types and constants for the frame fragment reassembler.
// Used by frr_front, frr_queue, frr_back and frame_fragment_reassembler_unit.
`default_nettype none

package frr_pkg;

   // Header layout, byte positions within a datagram
   localparam logic [15:0] HEADER_BYTES = 16'd20;
   localparam logic [15:0] TS_END       = 16'd8;
   localparam logic [15:0] LEN_END      = 16'd12;
   localparam logic [15:0] IDX_END      = 16'd16;
   localparam logic [15:0] HDR_LAST_POS = HEADER_BYTES - 16'd1;
   localparam logic [15:0] POS_MAX      = 16'hFFFF;

   localparam logic [15:0] PAYLOAD_BYTES_RESET = 16'd1480;

   // Offset/limit precompute is two stages deep
   localparam logic [1:0] FRESH_READY = 2'd2;

   // Queue between front and back; depth must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic        wr;
      logic        done;
      logic        drop;
      logic [7:0]  data;
      logic [15:0] offset;
      logic [31:0] base;
      logic [63:0] timestamp;
      logic [31:0] length;
   } frr_rec_type;

endpackage

`default_nettype wire

@@ hw/rtl/frr_queue.sv @@
// Small flop-based queue of classified records between front and back.
// Depends on frr_pkg for the record type and depth.
`default_nettype none

module frr_queue
   import frr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire frr_rec_type push_rec,
   output logic             full,
   input  wire logic        pop,
   output frr_rec_type      pop_rec,
   output logic             empty
);

   frr_rec_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_rec = entry_ff[rd_ptr_ff];

   always_comb begin
      // pointers wrap on their own, depth is a power of two
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_IDX_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_IDX_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/frr_front.sv @@
// Front end: header parse, fragment accept/drop, byte classification.
// Holds the payload_bytes register. Depends on frr_pkg.
`default_nettype none

module frr_front
   import frr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_last_byte,
   input  wire logic        q_full,
   output logic             q_push,
   output frr_rec_type      q_rec
);

   logic [15:0] pb_ff;
   logic [15:0] pos_ff, pos_in;
   logic [63:0] hdr_ts_ff, hdr_ts_in;
   logic [31:0] hdr_len_ff, hdr_len_in;
   logic [31:0] hdr_idx_ff, hdr_idx_in;
   logic [31:0] hdr_tot_ff, hdr_tot_in;
   logic [63:0] cur_ts_ff, cur_ts_in;
   logic [31:0] fs_ff, fs_in;
   logic [31:0] base_ff, base_in;
   logic [15:0] limit_ff, limit_in;
   logic        acc_ff, acc_in;

   // precompute pipeline, free running
   logic [47:0] prod_ff;
   logic        stale_ff, newer_ff;
   logic [31:0] pend_base_ff, pend_base_in;
   logic [15:0] pend_limit_ff, pend_limit_in;
   logic [1:0]  fresh_ff, fresh_in;

   logic        accept, judge, hdr_byte, beyond, touch;
   logic [31:0] room, fs_next, fs_now, tot_now;
   logic [15:0] p;
   logic        acc_now, drop, done, wr;

   assign req_full = q_full || ((pos_ff == HDR_LAST_POS) && (fresh_ff != FRESH_READY));
   assign accept   = req_push && !req_full;
   assign hdr_byte = (pos_ff < HEADER_BYTES);
   assign judge    = accept && (pos_ff == HDR_LAST_POS);

   // stage 2 of the precompute: clip fragment to the frame
   always_comb begin
      beyond = (prod_ff[47:32] != '0) || (prod_ff[31:0] >= hdr_len_ff);
      room   = hdr_len_ff - prod_ff[31:0];
      if (beyond) begin
         pend_base_in  = '0;
         pend_limit_in = '0;
      end else begin
         pend_base_in  = prod_ff[31:0];
         if ((room[31:16] == '0) && (room[15:0] < pb_ff)) begin
            pend_limit_in = room[15:0];
         end else begin
            pend_limit_in = pb_ff;
         end
      end
   end

   // anything that feeds the precompute restarts its settle count
   assign touch = csr_write_enable ||
                  (accept && ((pos_ff < IDX_END) || (pos_ff == HDR_LAST_POS)));

   always_comb begin
      if (touch) begin
         fresh_in = '0;
      end else if (fresh_ff == FRESH_READY) begin
         fresh_in = fresh_ff;
      end else begin
         fresh_in = fresh_ff + 2'd1;
      end
   end

   always_comb begin
      fs_next = newer_ff ? 32'd1 : fs_ff + 32'd1;
      acc_now = (pos_ff == HDR_LAST_POS) ? !stale_ff : acc_ff;
      fs_now  = (pos_ff == HDR_LAST_POS) ? fs_next : fs_ff;
      tot_now = (pos_ff == HDR_LAST_POS) ? {hdr_tot_ff[23:0], req_in_byte} : hdr_tot_ff;
      drop    = req_last_byte && ((pos_ff < HDR_LAST_POS) || !acc_now);
      done    = req_last_byte && !drop && (fs_now == tot_now);
      p       = pos_ff - HEADER_BYTES;
      wr      = !hdr_byte && acc_ff && (pos_ff != POS_MAX) && (p < limit_ff);
   end

   always_comb begin
      pos_in     = pos_ff;
      hdr_ts_in  = hdr_ts_ff;
      hdr_len_in = hdr_len_ff;
      hdr_idx_in = hdr_idx_ff;
      hdr_tot_in = hdr_tot_ff;
      cur_ts_in  = cur_ts_ff;
      fs_in      = fs_ff;
      base_in    = base_ff;
      limit_in   = limit_ff;
      acc_in     = acc_ff;
      if (accept) begin
         if (hdr_byte) begin
            if (pos_ff < TS_END) begin
               hdr_ts_in = {hdr_ts_ff[55:0], req_in_byte};
            end else if (pos_ff < LEN_END) begin
               hdr_len_in = {hdr_len_ff[23:0], req_in_byte};
            end else if (pos_ff < IDX_END) begin
               hdr_idx_in = {hdr_idx_ff[23:0], req_in_byte};
            end else begin
               hdr_tot_in = {hdr_tot_ff[23:0], req_in_byte};
            end
         end
         if (judge) begin
            acc_in = !stale_ff;
            if (!stale_ff) begin
               fs_in     = fs_next;
               cur_ts_in = hdr_ts_ff;
               base_in   = pend_base_ff;
               limit_in  = pend_limit_ff;
            end
         end
         if (req_last_byte) begin
            pos_in = '0;
            acc_in = 1'b0;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pb_ff      <= PAYLOAD_BYTES_RESET;
         pos_ff     <= '0;
         hdr_ts_ff  <= '0;
         hdr_len_ff <= '0;
         hdr_idx_ff <= '0;
         hdr_tot_ff <= '0;
         cur_ts_ff  <= '0;
         fs_ff      <= '0;
         base_ff    <= '0;
         limit_ff   <= '0;
         acc_ff     <= 1'b0;
         fresh_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            pb_ff <= csr_write_data;
         end
         pos_ff     <= pos_in;
         hdr_ts_ff  <= hdr_ts_in;
         hdr_len_ff <= hdr_len_in;
         hdr_idx_ff <= hdr_idx_in;
         hdr_tot_ff <= hdr_tot_in;
         cur_ts_ff  <= cur_ts_in;
         fs_ff      <= fs_in;
         base_ff    <= base_in;
         limit_ff   <= limit_in;
         acc_ff     <= acc_in;
         fresh_ff   <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= {16'd0, hdr_idx_ff} * {32'd0, pb_ff};
      stale_ff      <= (hdr_ts_ff < cur_ts_ff);
      newer_ff      <= (hdr_ts_ff > cur_ts_ff);
      pend_base_ff  <= pend_base_in;
      pend_limit_ff <= pend_limit_in;
   end

   always_comb begin
      q_push          = accept;
      q_rec.wr        = wr;
      q_rec.done      = done;
      q_rec.drop      = drop;
      q_rec.data      = req_in_byte;
      q_rec.offset    = p;
      q_rec.base      = base_ff;
      q_rec.timestamp = hdr_ts_ff;
      q_rec.length    = hdr_len_ff;
   end

endmodule

`default_nettype wire

@@ hw/rtl/frr_back.sv @@
// Back end: forms the frame-store write address and holds the result register.
// Depends on frr_pkg for the record type.
`default_nettype none

module frr_back
   import frr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_empty,
   input  wire frr_rec_type  q_rec,
   output logic              q_pop,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output logic              rsp_write_valid,
   output logic [31:0]       rsp_write_address,
   output logic [7:0]        rsp_write_data,
   output logic              rsp_frame_done,
   output logic [63:0]       rsp_done_timestamp,
   output logic [31:0]       rsp_done_length,
   output logic              rsp_datagram_dropped
);

   logic        valid_ff, valid_in;
   logic        wv_ff, done_ff, drop_ff;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  data_ff;
   logic [63:0] ts_ff;
   logic [31:0] len_ff;

   // refill when the result register is free or being drained
   assign q_pop   = !q_empty && (!valid_ff || rsp_pop);
   assign addr_in = q_rec.base + {16'd0, q_rec.offset};

   always_comb begin
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         wv_ff   <= q_rec.wr;
         addr_ff <= q_rec.wr ? addr_in : '0;
         data_ff <= q_rec.wr ? q_rec.data : '0;
         done_ff <= q_rec.done;
         ts_ff   <= q_rec.done ? q_rec.timestamp : '0;
         len_ff  <= q_rec.done ? q_rec.length : '0;
         drop_ff <= q_rec.drop;
      end
   end

   assign rsp_empty            = !valid_ff;
   assign rsp_write_valid      = wv_ff;
   assign rsp_write_address    = addr_ff;
   assign rsp_write_data       = data_ff;
   assign rsp_frame_done       = done_ff;
   assign rsp_done_timestamp   = ts_ff;
   assign rsp_done_length      = len_ff;
   assign rsp_datagram_dropped = drop_ff;

endmodule

`default_nettype wire

@@ hw/rtl/frame_fragment_reassembler_unit.sv @@
// Top level of the frame fragment reassembler.
// Instantiates frr_front, frr_queue and frr_back; depends on frr_pkg.
`default_nettype none

// Takes received datagrams one byte per clock (req_last_byte marks the final
// byte), parses the 20-byte big-endian header and produces one result per
// byte: a frame-store write, a frame-done flag or a drop flag. Sustained rate
// is one byte per clock while req_full is low. The header decision at the
// 20th byte uses a two-stage precompute (fragment index times payload_bytes,
// then clipping to the frame length); a write to payload_bytes inside a
// datagram's header can hold req_full high at that byte. Results go through
// the queue and the result register to the rsp_ ports; the four-entry queue
// and the result register absorb stalls on the rsp_ side before req_full rises.
module frame_fragment_reassembler_unit
   import frr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_write_valid,
   output logic [31:0]      rsp_write_address,
   output logic [7:0]       rsp_write_data,
   output logic             rsp_frame_done,
   output logic [63:0]      rsp_done_timestamp,
   output logic [31:0]      rsp_done_length,
   output logic             rsp_datagram_dropped
);

   logic        q_full, q_push, q_empty, q_pop;
   frr_rec_type push_rec, pop_rec;

   frr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_in_byte      (req_in_byte),
      .req_last_byte    (req_last_byte),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_rec            (push_rec)
   );

   frr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (push_rec),
      .full     (q_full),
      .pop      (q_pop),
      .pop_rec  (pop_rec),
      .empty    (q_empty)
   );

   frr_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (q_empty),
      .q_rec                (pop_rec),
      .q_pop                (q_pop),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_write_valid      (rsp_write_valid),
      .rsp_write_address    (rsp_write_address),
      .rsp_write_data       (rsp_write_data),
      .rsp_frame_done       (rsp_frame_done),
      .rsp_done_timestamp   (rsp_done_timestamp),
      .rsp_done_length      (rsp_done_length),
      .rsp_datagram_dropped (rsp_datagram_dropped)
   );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Testbench for frame_fragment_reassembler_unit: drives datagram bytes, predicts
// every per-byte result and checks each one in order against the block.
// Depends on frr_pkg and frame_fragment_reassembler_unit only.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import frr_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   // Field order matches the concatenation of the rsp_ ports
   typedef struct packed {
      logic        wr_valid;
      logic [31:0] wr_addr;
      logic [7:0]  wr_data;
      logic        done;
      logic [63:0] done_ts;
      logic [31:0] done_len;
      logic        dropped;
   } frag_result_type;

   class frag_scoreboard;
      frag_result_type expected_q[$];
      int           errors;
      logic [15:0]  payload_bytes;
      logic [15:0]  byte_pos;
      logic [63:0]  hdr_ts;
      logic [31:0]  hdr_len;
      logic [31:0]  hdr_idx;
      logic [31:0]  hdr_tot;
      logic [63:0]  cur_ts;
      logic [31:0]  seen;
      logic [31:0]  base_q;
      logic [15:0]  limit_q;
      logic         accepted;

      function new();
         errors        = 0;
         payload_bytes = PAYLOAD_BYTES_RESET;
         byte_pos      = '0;
         hdr_ts        = '0;
         hdr_len       = '0;
         hdr_idx       = '0;
         hdr_tot       = '0;
         cur_ts        = '0;
         seen          = '0;
         base_q        = '0;
         limit_q       = '0;
         accepted      = 1'b0;
      endfunction

      function void set_payload_bytes(logic [15:0] value);
         payload_bytes = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Advance the reassembly state by one accepted byte and queue its result
      function void note_byte(logic [7:0] b, logic last);
         frag_result_type r;
         logic [47:0]  product;
         logic [31:0]  room;
         logic [15:0]  p;
         r = '0;
         if (byte_pos < HEADER_BYTES) begin
            if (byte_pos < TS_END) hdr_ts = {hdr_ts[55:0], b};
            else if (byte_pos < LEN_END) hdr_len = {hdr_len[23:0], b};
            else if (byte_pos < IDX_END) hdr_idx = {hdr_idx[23:0], b};
            else hdr_tot = {hdr_tot[23:0], b};
            if (byte_pos == HDR_LAST_POS) begin
               if (hdr_ts < cur_ts) begin
                  accepted = 1'b0;
               end else begin
                  if (hdr_ts > cur_ts) begin
                     seen   = '0;
                     cur_ts = hdr_ts;
                  end
                  seen     = seen + 32'd1;
                  accepted = 1'b1;
                  product  = 48'(hdr_idx) * 48'(payload_bytes);
                  if (product >= 48'(hdr_len)) begin
                     base_q  = '0;
                     limit_q = '0;
                  end else begin
                     room    = hdr_len - product[31:0];
                     base_q  = product[31:0];
                     limit_q = (room < 32'(payload_bytes)) ? room[15:0] : payload_bytes;
                  end
               end
            end
         end else if (accepted && byte_pos != POS_MAX) begin
            p = byte_pos - HEADER_BYTES;
            if (p < limit_q) begin
               r.wr_valid = 1'b1;
               r.wr_addr  = base_q + 32'(p);
               r.wr_data  = b;
            end
         end
         if (last) begin
            if (byte_pos < HDR_LAST_POS || !accepted) begin
               r.dropped = 1'b1;
            end else if (seen == hdr_tot) begin
               r.done     = 1'b1;
               r.done_ts  = cur_ts;
               r.done_len = hdr_len;
            end
            byte_pos = '0;
            accepted = 1'b0;
         end else if (byte_pos != POS_MAX) begin
            byte_pos = byte_pos + 16'd1;
         end
         expected_q.push_back(r);
      endfunction

      function void check_result(frag_result_type got);
         frag_result_type exp_r;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%t: result transfer with nothing pending: wv=%0d addr=%0h data=%0h",
                        $realtime, got.wr_valid, got.wr_addr, got.wr_data);
            return;
         end
         exp_r = expected_q.pop_front();
         if (got !== exp_r) begin
            errors++;
            if (errors <= 10) begin
               $display("%t: mismatch exp wv=%0d addr=%0h data=%0h done=%0d ts=%0h len=%0h drop=%0d",
                        $realtime, exp_r.wr_valid, exp_r.wr_addr, exp_r.wr_data, exp_r.done,
                        exp_r.done_ts, exp_r.done_len, exp_r.dropped);
               $display("             got wv=%0d addr=%0h data=%0h done=%0d ts=%0h len=%0h drop=%0d",
                        got.wr_valid, got.wr_addr, got.wr_data, got.done,
                        got.done_ts, got.done_len, got.dropped);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_in_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_write_valid;
   logic [31:0] rsp_write_address;
   logic [7:0]  rsp_write_data;
   logic        rsp_frame_done;
   logic [63:0] rsp_done_timestamp;
   logic [31:0] rsp_done_length;
   logic        rsp_datagram_dropped;

   frag_scoreboard sb;
   int             items_sent = 0;
   int             burst_left = 0;
   int             pop_phase = 0;
   int             pop_mode = 0;
   int             idle_cycles = 0;
   logic [63:0]    frame_ts = '0;

   frame_fragment_reassembler_unit u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_in_byte          (req_in_byte),
      .req_last_byte        (req_last_byte),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_write_valid      (rsp_write_valid),
      .rsp_write_address    (rsp_write_address),
      .rsp_write_data       (rsp_write_data),
      .rsp_frame_done       (rsp_frame_done),
      .rsp_done_timestamp   (rsp_done_timestamp),
      .rsp_done_length      (rsp_done_length),
      .rsp_datagram_dropped (rsp_datagram_dropped)
   );

   always #5 clock = ~clock;

   // Receiver: pops with a randomly chosen pattern that is re-picked when its phase runs out
   always @(posedge clock) begin
      if (pop_phase == 0) begin
         pop_mode  = $urandom_range(0, 3);
         pop_phase = $urandom_range(50, 300);
      end
      pop_phase--;
      case (pop_mode)
         0: begin
            rsp_pop <= 1'b1;
         end
         1: begin
            rsp_pop <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_pop <= (pop_phase % 4 == 0);
         end
         default: begin
            rsp_pop <= (pop_phase % 16 >= 12);
         end
      endcase
   end

   // Transfer monitor and watchdog; values seen here are the pre-edge ones
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) sb.set_payload_bytes(csr_write_data);
         if (req_push && !req_full) sb.note_byte(req_in_byte, req_last_byte);
         if (rsp_pop && !rsp_empty)
            sb.check_result({rsp_write_valid, rsp_write_address, rsp_write_data, rsp_frame_done,
                             rsp_done_timestamp, rsp_done_length, rsp_datagram_dropped});
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write_enable)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 400)
                                                 : $urandom_range(1, 48);
      end
      burst_left--;
      req_push      <= 1'b1;
      req_in_byte   <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   // Header goes out big-endian, the rest is random payload
   task automatic send_datagram(input logic [63:0] ts, input logic [31:0] len,
                                input logic [31:0] idx, input logic [31:0] tot,
                                input int nbytes);
      logic [159:0] hdr;
      hdr = {ts, len, idx, tot};
      for (int i = 0; i < nbytes; i++)
         push_byte((i < 20) ? hdr[159 - 8 * i -: 8] : 8'($urandom_range(0, 255)),
                   i == nbytes - 1);
   endtask

   // Stop sending and wait until every expected result has been popped
   task automatic settle();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_payload_bytes(input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [15:0] pb;
      logic [31:0] cur_len;
      logic [31:0] cur_tot;
      int          k;
      int          target;
      int          j;
      int          tmp;
      int          nb;
      int          order[8];

      sb      = new();
      cur_len = 32'd16;
      cur_tot = 32'd1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: drops, equal/newer/stale timestamps, clipping, extremes
      write_payload_bytes(16'd4);
      send_datagram('1, '1, '1, '1, 1);                    // short, one byte
      send_datagram('1, '1, '1, '1, 19);                   // short, header minus one
      send_datagram(64'd0, 32'd10, 32'd0, 32'd3, 24);      // joins frame at timestamp 0
      send_datagram(64'd0, 32'd10, 32'd1, 32'd3, 26);      // excess payload
      send_datagram(64'd0, 32'd10, 32'd2, 32'd3, 24);      // clipped to length, completes
      send_datagram(64'd5, 32'd8, 32'd3, 32'd1, 24);       // newer, fragment beyond frame
      send_datagram(64'd4, 32'd8, 32'd0, 32'd1, 22);       // stale
      send_datagram(64'd5, 32'd8, 32'd0, 32'd2, 20);       // header only, completes
      send_datagram(64'd5, '1, '1, 32'd9, 23);             // huge index, no writes
      send_datagram(64'd5, '1, 32'd0, 32'd4, 26);
      settle();
      write_payload_bytes(16'd0);
      send_datagram(64'd6, 32'd100, 32'd0, 32'd1, 24);     // zero payload size writes nothing
      settle();
      write_payload_bytes(16'hFFFF);
      send_datagram(64'd7, '1, 32'd1, 32'd3, 26);
      send_datagram(64'd7, '1, 32'h0001_0000, 32'd3, 22);  // product 0xFFFF0000, still inside 32 bits
      send_datagram(64'd7, '1, '1, 32'd3, 21);
      frame_ts = 64'd7;

      // Random phases, mostly well-formed frames with noise mixed in
      for (int ph = 0; ph < 5; ph++) begin
         pb = (ph == 0) ? 16'd1 : 16'($urandom_range(2, 16));
         settle();
         write_payload_bytes(pb);
         target = items_sent + 40;
         while (items_sent < target) begin
            k = $urandom_range(0, 9);
            if (k == 0) begin
               send_datagram({$urandom, $urandom}, $urandom, $urandom, $urandom,
                             $urandom_range(1, 19));
            end else if (k == 1) begin
               send_datagram(frame_ts - 64'($urandom_range(1, 4)), $urandom,
                             $urandom_range(0, 3), $urandom_range(1, 3),
                             20 + $urandom_range(0, pb + 2));
            end else if (k == 2) begin
               // repeat of a fragment of the current frame, or the index just past it
               send_datagram(frame_ts, cur_len, $urandom_range(0, cur_tot), cur_tot,
                             20 + $urandom_range(0, pb + 2));
            end else begin
               frame_ts = frame_ts + (($urandom_range(0, 7) == 0) ? ({32'h0, $urandom} << 20)
                                                                   : 64'($urandom_range(1, 3)));
               cur_tot = $urandom_range(1, 5);
               cur_len = cur_tot * pb - $urandom_range(0, pb - 1);
               if (k == 9) cur_len = cur_len + $urandom_range(0, 2 * pb);
               for (j = 0; j < 8; j++) order[j] = j;
               for (j = cur_tot - 1; j > 0; j--) begin
                  nb       = $urandom_range(0, j);
                  tmp      = order[j];
                  order[j] = order[nb];
                  order[nb] = tmp;
               end
               for (j = 0; j < cur_tot; j++) begin
                  if ($urandom_range(0, 7) == 0)
                     send_datagram(frame_ts - 64'd1, $urandom, 32'd0, 32'd1,
                                   $urandom_range(1, 30));
                  nb = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 20 + 2 * pb) : 20 + pb;
                  send_datagram(frame_ts, cur_len, order[j], cur_tot, nb);
               end
            end
         end
      end

      // Largest timestamp last, since everything after it would be stale
      send_datagram('1, '1, '1, '1, 22);
      send_datagram('1, '1, 32'd0, 32'd2, 24);
      settle();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
